/* sv/ordered_list_insert_delete_find_assert.svh */
// ----------------------------------------------------------------------------
// ordered list assertion macros
// concurrent checks, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_FIND_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_FIND_ASSERT_SVH

`ifndef ASSERT_OFF

// check that is skipped while reset is high
`define OLI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that holds in every cycle, reset included
`define OLI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OLI_ASSERT(lbl, clk, rst, prop, msg)
`define OLI_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/oli_pkg.sv */
// ----------------------------------------------------------------------------
// oli_pkg
// shared types, command codes and helpers of the ordered list
// ----------------------------------------------------------------------------
package oli_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  // width of one scan step over the match row
  localparam int CHUNK   = 8;
  localparam int CHUNK_W = 3;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic        ins;
    logic        del;
    logic [7:0]  pos0;   // 0-based position
    logic [31:0] value;
  } cell_ctrl_t;

  // lowest set bit of a scan chunk
  function automatic logic [CHUNK_W-1:0] first_set(input logic [CHUNK-1:0] v);
    logic [CHUNK_W-1:0] idx;
    idx = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CHUNK_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* sv/ordered_list_insert_delete_find.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_find
// bounded positional list of 32-bit values held in a row of cells
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir
//  in      | in_valid, in_stall, cmd, position, value | in
//  out     | out_valid, out_stall, ok, found_position, count | out
//
//  insert and delete: execute, then done; all cells shift at once
//  find: execute, scan steps, then done; the match row is scanned 8 bits a cycle
//  one item at a time; the next item is taken once the result sits in the
//  output register, even while out_stall holds it there
//  reset (rst, synchronous) empties the list; entries themselves are not cleared
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_find #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               ok,
  output logic [7:0]         found_position,
  output logic [7:0]         count
);
  import oli_pkg::*;
  `include "ordered_list_insert_delete_find_assert.svh"

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int SW = ((CAPACITY + CHUNK - 1) / CHUNK) * CHUNK;
  localparam int BW = $clog2(SW + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_DONE} state_t;

  state_t        state;
  logic [1:0]    op;
  logic [7:0]    pos;
  logic [31:0]   val;
  logic [LW-1:0] len;
  logic [SW-1:0] match_vec;
  logic [BW-1:0] base;
  logic          res_ok;
  logic [7:0]    res_pos;

  logic [CAPACITY-1:0] hit;
  logic [31:0]         cell_data [CAPACITY];
  cell_ctrl_t          ctrl;
  logic                ins_ok;
  logic                del_ok;
  logic [CHUNK-1:0]    chunk;
  logic [CHUNK_W-1:0]  first;

  assign in_stall = (state != S_IDLE);

  assign ins_ok = (32'(len) < CAPACITY) && (pos != '0) &&
                  (32'(pos) <= 32'(len) + 32'd1);
  assign del_ok = (pos != '0) && (32'(pos) <= 32'(len));

  always_comb begin
    ctrl.ins   = (state == S_EXEC) && (op == CMD_INSERT) && ins_ok;
    ctrl.del   = (state == S_EXEC) && (op == CMD_DELETE) && del_ok;
    ctrl.pos0  = pos - 8'd1;
    ctrl.value = val;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] lower;
    logic [31:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_next
      assign upper = cell_data[i+1];
    end
    oli_cell #(
      .INDEX (i),
      .LW    (LW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_lower (lower),
      .from_upper (upper),
      .length     (len),
      .data       (cell_data[i]),
      .hit        (hit[i])
    );
  end

  assign chunk = match_vec[CHUNK-1:0];
  assign first = first_set(chunk);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      len       <= '0;
    end else begin
      // a result loaded below takes over the register instead
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= cmd;
            pos   <= position;
            val   <= value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_pos <= '0;
          case (op)
            CMD_INSERT: begin
              res_ok <= ins_ok;
              if (ins_ok) begin
                len <= len + LW'(1);
              end
              state <= S_DONE;
            end
            CMD_DELETE: begin
              res_ok <= del_ok;
              if (del_ok) begin
                len <= len - LW'(1);
              end
              state <= S_DONE;
            end
            CMD_FIND: begin
              match_vec <= SW'(hit);
              base      <= '0;
              state     <= S_SCAN;
            end
            default: begin
              res_ok <= 1'b0;
              state  <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (chunk != '0) begin
            res_ok  <= 1'b1;
            res_pos <= 8'(32'(base) + 32'(first) + 32'd1);
            state   <= S_DONE;
          end else if ((match_vec >> CHUNK) == '0) begin
            res_ok  <= 1'b0;
            res_pos <= '0;
            state   <= S_DONE;
          end else begin
            match_vec <= match_vec >> CHUNK;
            base      <= base + BW'(CHUNK);
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (!out_valid || !out_stall) begin
            ok             <= res_ok;
            found_position <= res_pos;
            count          <= 8'(len);
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OLI_ASSERT(a_len_bound, clk, rst, (32'(len) <= CAPACITY), "list length above capacity")
  `OLI_ASSERT(a_len_only_exec, clk, rst, (state != S_EXEC) |=> $stable(len), "length moved outside execute")
  `OLI_ASSERT(a_scan_is_find, clk, rst, (state == S_SCAN) |-> (op == CMD_FIND), "scan without a find")
  `OLI_ASSERT(a_pos_needs_ok, clk, rst, (out_valid && found_position != '0) |-> ok, "position reported without match")

endmodule

/* sv/oli_cell.sv */
// ----------------------------------------------------------------------------
// oli_cell
// one list entry: loads, shifts up or down with its neighbors, compares
// ----------------------------------------------------------------------------
module oli_cell #(
  parameter int INDEX = 0,
  parameter int LW    = 8
) (
  input  logic               clk,
  input  oli_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]        from_lower,
  input  logic [31:0]        from_upper,
  input  logic [LW-1:0]      length,
  output logic [31:0]        data,
  output logic               hit
);
  import oli_pkg::*;

  logic at;
  logic above;

  assign at    = (INDEX == int'(ctrl.pos0));
  assign above = (INDEX > int'(ctrl.pos0));

  always_ff @(posedge clk) begin
    if (ctrl.ins && at) begin
      data <= ctrl.value;
    end else if (ctrl.ins && above) begin
      data <= from_lower;
    end else if (ctrl.del && (at || above)) begin
      data <= from_upper;
    end
  end

  // only live entries take part in a search
  assign hit = (data == ctrl.value) && (INDEX < int'(length));

endmodule
